FILE: rtl/ame_pkg.sv
// ----------------------------------------------------------------------------
// ame_pkg
// Shared types, codes and helpers of the accumulator machine execute block.
// ----------------------------------------------------------------------------
package ame_pkg;

	localparam int NUM_SLOTS  = 7;
	localparam int DATA_WIDTH = 32;
	localparam int SLOT_AW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
	localparam int CNT_W      = $clog2(DATA_WIDTH);
	localparam int IN_W       = 40;
	localparam int OUT_W      = 72;

	typedef logic [DATA_WIDTH-1:0] data_t;

	localparam logic [3:0] OP_SET   = 4'd0;
	localparam logic [3:0] OP_LOADI = 4'd1;
	localparam logic [3:0] OP_LOAD  = 4'd2;
	localparam logic [3:0] OP_ADD   = 4'd3;
	localparam logic [3:0] OP_SUB   = 4'd4;
	localparam logic [3:0] OP_MULT  = 4'd5;
	localparam logic [3:0] OP_DIV   = 4'd6;
	localparam logic [3:0] OP_STORE = 4'd7;
	localparam logic [3:0] OP_END   = 4'd8;

	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_ENDED   = 3'd1,
		ST_BADOP   = 3'd2,
		ST_BADSLOT = 3'd3,
		ST_DIVZERO = 3'd4,
		ST_HALTED  = 3'd5
	} status_t;

	typedef enum logic [1:0] {
		ALU_ADD = 2'd0,
		ALU_SUB = 2'd1,
		ALU_MUL = 2'd2,
		ALU_DIV = 2'd3
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
		data_t   a;
		data_t   b;
	} alu_req_t;

	typedef struct packed {
		logic  done;
		data_t result;
	} alu_rsp_t;

	function automatic data_t imm_to_data(logic [31:0] v);
		logic [63:0] w;
		w = {{32{v[31]}}, v};
		return w[DATA_WIDTH-1:0];
	endfunction

	function automatic logic [31:0] data_to_out(data_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[31:0];
	endfunction

endpackage

FILE: rtl/ame_ram.sv
// ----------------------------------------------------------------------------
// ame_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ame_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

FILE: rtl/ame_alu.sv
// ----------------------------------------------------------------------------
// ame_alu
// Shared iterative unit: one adder serves add, subtract, shift-add multiply
// and restoring signed divide, one step per cycle.
// ----------------------------------------------------------------------------
module ame_alu import ame_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	typedef enum logic [5:0] {
		A_IDLE = 6'b000001,
		A_NEGA = 6'b000010,
		A_NEGB = 6'b000100,
		A_MUL  = 6'b001000,
		A_DIV  = 6'b010000,
		A_NEGQ = 6'b100000
	} alu_state_t;

	alu_state_t        st_q;
	logic [CNT_W-1:0]  cnt_q;
	data_t             acc_q;
	data_t             opa_q;
	data_t             opb_q;
	logic              neg_q;
	logic              done_q;
	data_t             res_q;

	logic [DATA_WIDTH:0] add_x;
	logic [DATA_WIDTH:0] add_y;
	logic                add_ci;
	logic [DATA_WIDTH:0] sum;
	data_t               shifted;
	logic                done_d;

	assign shifted = {acc_q[DATA_WIDTH-2:0], opa_q[DATA_WIDTH-1]};

	assign done_d = ((st_q == A_IDLE) && req.start && (req.op inside {ALU_ADD, ALU_SUB})) ||
	                ((st_q == A_MUL) && (cnt_q == '0)) ||
	                (st_q == A_NEGQ);

	always_comb begin
		add_x  = '0;
		add_y  = '0;
		add_ci = 1'b0;
		case (st_q)
			A_IDLE: begin
				add_x = {1'b0, req.a};
				if (req.op == ALU_SUB) begin
					add_y  = {1'b0, ~req.b};
					add_ci = 1'b1;
				end else begin
					add_y = {1'b0, req.b};
				end
			end
			A_NEGA: begin
				add_x  = {1'b0, opa_q[DATA_WIDTH-1] ? ~opa_q : opa_q};
				add_ci = opa_q[DATA_WIDTH-1];
			end
			A_NEGB: begin
				add_x  = {1'b0, opb_q[DATA_WIDTH-1] ? ~opb_q : opb_q};
				add_ci = opb_q[DATA_WIDTH-1];
			end
			A_MUL: begin
				add_x = {1'b0, acc_q};
				add_y = opb_q[0] ? {1'b0, opa_q} : '0;
			end
			A_DIV: begin
				add_x  = {1'b0, shifted};
				add_y  = ~{1'b0, opb_q};
				add_ci = 1'b1;
			end
			A_NEGQ: begin
				add_x  = {1'b0, neg_q ? ~opa_q : opa_q};
				add_ci = neg_q;
			end
			default: begin
				add_x = '0;
			end
		endcase
	end

	assign sum = add_x + add_y + {{DATA_WIDTH{1'b0}}, add_ci};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= A_IDLE;
			cnt_q  <= '0;
			acc_q  <= '0;
			opa_q  <= '0;
			opb_q  <= '0;
			neg_q  <= 1'b0;
			done_q <= 1'b0;
			res_q  <= '0;
		end else begin
			done_q <= done_d;
			case (st_q)
				A_IDLE: begin
					if (req.start) begin
						opa_q <= req.a;
						opb_q <= req.b;
						acc_q <= '0;
						neg_q <= req.a[DATA_WIDTH-1] ^ req.b[DATA_WIDTH-1];
						cnt_q <= CNT_W'(DATA_WIDTH - 1);
						case (req.op)
							ALU_MUL: st_q <= A_MUL;
							ALU_DIV: st_q <= A_NEGA;
							default: begin
								res_q <= sum[DATA_WIDTH-1:0];
							end
						endcase
					end
				end
				A_NEGA: begin
					opa_q <= sum[DATA_WIDTH-1:0];
					st_q  <= A_NEGB;
				end
				A_NEGB: begin
					opb_q <= sum[DATA_WIDTH-1:0];
					st_q  <= A_DIV;
				end
				A_MUL: begin
					acc_q <= sum[DATA_WIDTH-1:0];
					opa_q <= {opa_q[DATA_WIDTH-2:0], 1'b0};
					opb_q <= {1'b0, opb_q[DATA_WIDTH-1:1]};
					if (cnt_q == '0) begin
						res_q <= sum[DATA_WIDTH-1:0];
						st_q  <= A_IDLE;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				A_DIV: begin
					acc_q <= sum[DATA_WIDTH] ? shifted : sum[DATA_WIDTH-1:0];
					opa_q <= {opa_q[DATA_WIDTH-2:0], ~sum[DATA_WIDTH]};
					if (cnt_q == '0) begin
						st_q <= A_NEGQ;
					end else begin
						cnt_q <= cnt_q - 1'b1;
					end
				end
				A_NEGQ: begin
					res_q <= sum[DATA_WIDTH-1:0];
					st_q  <= A_IDLE;
				end
				default: begin
					st_q <= A_IDLE;
				end
			endcase
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = res_q;

endmodule

FILE: rtl/accumulator_machine_execute.sv
// ----------------------------------------------------------------------------
// accumulator_machine_execute
// Executes one accumulator-machine instruction per input item against a small
// slot file and answers each with one status item.
// ----------------------------------------------------------------------------
// LOADI, END, halted, bad operator and bad slot go straight to the result;
// LOAD, STORE and divide by zero first read the slot; ADD, SUB, MULT and DIV
// read the slot and then wait for the shared unit. One item at a time; the next
// item can be taken in the cycle after the result is registered. MULT and DIV
// run on the shared unit's one adder, one step per cycle. Reset clears the
// accumulator, the slot valid bits (slots read as zero) and halt flag at once.
module accumulator_machine_execute import ame_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  logic [IN_W-1:0]  s_tdata,   // action[3:0], operand[35:4], zero pad
	output logic             m_tvalid,
	input  logic             m_tready,
	output logic [OUT_W-1:0] m_tdata    // status[2:0], accumulator[34:3],
	                                    // slot_value[66:35], zero pad
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_READ = 4'b0010,
		S_WAIT = 4'b0100,
		S_DONE = 4'b1000
	} state_t;

	state_t              st_q;
	logic                halted_q;
	data_t               acc_q;
	data_t               sv_q;
	data_t               v_q;
	status_t             status_q;
	logic [3:0]          action_q;
	logic [SLOT_AW-1:0]  idx_q;
	logic [NUM_SLOTS-1:0] valid_q;
	logic                m_tvalid_q;
	logic [OUT_W-1:0]    m_tdata_q;

	logic                accept;
	logic [3:0]          in_action;
	logic [31:0]         in_operand;
	logic                slot_ok;
	logic [SLOT_AW-1:0]  in_idx;
	data_t               ram_rdata;
	data_t               v;
	logic                idx_zero;
	logic                ram_we;
	logic                div_zero;
	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;

	assign in_action  = s_tdata[3:0];
	assign in_operand = s_tdata[35:4];
	assign in_idx     = in_operand[SLOT_AW-1:0];
	assign slot_ok    = in_operand < 32'(NUM_SLOTS);
	assign s_tready   = (st_q == S_IDLE);
	assign accept     = s_tvalid && s_tready;

	assign idx_zero = (idx_q == '0);
	assign v        = idx_zero ? acc_q : (valid_q[idx_q] ? ram_rdata : '0);
	assign div_zero = (v == '0);
	assign ram_we   = (st_q == S_READ) && (action_q == OP_STORE) && !idx_zero;

	ame_ram #(
		.WIDTH(DATA_WIDTH),
		.DEPTH(NUM_SLOTS)
	) u_slots (
		.clk   (clk),
		.we    (ram_we),
		.waddr (idx_q),
		.wdata (acc_q),
		.re    (accept),
		.raddr (in_idx),
		.rdata (ram_rdata)
	);

	always_comb begin
		alu_req.start = 1'b0;
		alu_req.op    = ALU_ADD;
		alu_req.a     = acc_q;
		alu_req.b     = v;
		if (st_q == S_READ) begin
			case (action_q)
				OP_ADD: alu_req.start = 1'b1;
				OP_SUB: begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_SUB;
				end
				OP_MULT: begin
					alu_req.start = 1'b1;
					alu_req.op    = ALU_MUL;
				end
				OP_DIV: begin
					alu_req.start = !div_zero;
					alu_req.op    = ALU_DIV;
				end
				default: alu_req.start = 1'b0;
			endcase
		end
	end

	ame_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.rsp    (alu_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			halted_q   <= 1'b0;
			acc_q      <= '0;
			sv_q       <= '0;
			v_q        <= '0;
			status_q   <= ST_OK;
			action_q   <= OP_SET;
			idx_q      <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
		end else begin
			if (m_tvalid_q && m_tready && (st_q != S_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (st_q)
				S_IDLE: begin
					if (accept) begin
						action_q <= in_action;
						idx_q    <= in_idx;
						sv_q     <= (!halted_q && (in_action == OP_LOADI)) ?
						            imm_to_data(in_operand) : acc_q;
						if (halted_q) begin
							status_q <= ST_HALTED;
							st_q     <= S_DONE;
						end else begin
							case (in_action)
								OP_END: begin
									halted_q <= 1'b1;
									status_q <= ST_ENDED;
									st_q     <= S_DONE;
								end
								OP_LOADI: begin
									acc_q    <= imm_to_data(in_operand);
									status_q <= ST_OK;
									st_q     <= S_DONE;
								end
								OP_LOAD, OP_ADD, OP_SUB, OP_MULT, OP_DIV, OP_STORE: begin
									if (slot_ok) begin
										status_q <= ST_OK;
										st_q     <= S_READ;
									end else begin
										halted_q <= 1'b1;
										status_q <= ST_BADSLOT;
										st_q     <= S_DONE;
									end
								end
								default: begin
									halted_q <= 1'b1;
									status_q <= ST_BADOP;
									st_q     <= S_DONE;
								end
							endcase
						end
					end
				end
				S_READ: begin
					case (action_q)
						OP_LOAD: begin
							acc_q <= v;
							sv_q  <= v;
							st_q  <= S_DONE;
						end
						OP_STORE: begin
							acc_q <= '0;
							sv_q  <= idx_zero ? '0 : acc_q;
							if (!idx_zero) begin
								valid_q[idx_q] <= 1'b1;
							end
							st_q <= S_DONE;
						end
						default: begin
							if ((action_q == OP_DIV) && div_zero) begin
								halted_q <= 1'b1;
								status_q <= ST_DIVZERO;
								sv_q     <= acc_q;
								st_q     <= S_DONE;
							end else begin
								v_q  <= v;
								st_q <= S_WAIT;
							end
						end
					endcase
				end
				S_WAIT: begin
					if (alu_rsp.done) begin
						acc_q <= alu_rsp.result;
						sv_q  <= idx_zero ? alu_rsp.result : v_q;
						st_q  <= S_DONE;
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_tdata_q  <= {5'b0, data_to_out(sv_q), data_to_out(acc_q), status_q};
						st_q       <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

`ifndef SYNTHESIS
	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	a_alu_start_in_read: assert property (@(posedge clk) disable iff (!arst_n)
		alu_req.start |-> (st_q == S_READ) && !halted_q)
		else $error("shared unit started outside slot read");

	a_alu_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (st_q == S_WAIT))
		else $error("shared unit result with no instruction waiting");

	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (32'(idx_q) < 32'(NUM_SLOTS)))
		else $error("slot write out of range");
`endif

endmodule

FILE: test/tb_accumulator_machine_execute.sv
// ----------------------------------------------------------------------------
// tb_accumulator_machine_execute
// Self-checking bench for the accumulator machine execute block. Instruction
// items are run through a behavioral model of the slot file and halt flag, and
// every result item is compared field by field with the oldest prediction.
// Directed programs hit the arithmetic corners first. Long random programs
// follow, then a long output hold-off. One randomly chosen halting cause ends
// the run, followed by noise items that must all report the halted state.
// ----------------------------------------------------------------------------
module tb_accumulator_machine_execute;
	import ame_pkg::*;

	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned HOLD_CYCLES  = 400;
	localparam int unsigned DRAIN_CYCLES = 60;

	typedef struct {
		status_t     status;
		logic [31:0] acc;
		logic [31:0] slot_val;
	} outcome_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             s_tvalid = 1'b0;
	logic             s_tready;
	logic [IN_W-1:0]  s_tdata = '0;
	logic             m_tvalid;
	logic             m_tready = 1'b0;
	logic [OUT_W-1:0] m_tdata;

	data_t       mach_slots [NUM_SLOTS];
	bit          mach_halted = 1'b0;
	outcome_t    pending_results [$];
	int unsigned err_count = 0;
	int unsigned burst_left = 0;
	bit          gaps_on = 1'b1;
	bit          hold_off_req = 1'b0;

	accumulator_machine_execute dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		foreach (mach_slots[i]) mach_slots[i] = '0;
	end

	function automatic outcome_t execute_instr(input logic [3:0] act, input logic [31:0] opnd);
		outcome_t           res;
		data_t              src;
		logic signed [63:0] num;
		logic signed [63:0] den;
		logic signed [63:0] quo;
		int unsigned        idx;
		idx = 0;
		res.status = ST_OK;
		if (mach_halted) begin
			res.status = ST_HALTED;
		end else if (act == OP_END) begin
			mach_halted = 1'b1;
			res.status = ST_ENDED;
		end else if (act == OP_LOADI) begin
			mach_slots[0] = data_t'($signed(opnd));
		end else if (act < OP_LOAD || act > OP_STORE) begin
			mach_halted = 1'b1;
			res.status = ST_BADOP;
		end else if (opnd >= NUM_SLOTS) begin
			mach_halted = 1'b1;
			res.status = ST_BADSLOT;
		end else begin
			idx = opnd;
			src = mach_slots[idx];
			case (act)
				OP_LOAD: mach_slots[0] = src;
				OP_ADD:  mach_slots[0] = mach_slots[0] + src;
				OP_SUB:  mach_slots[0] = mach_slots[0] - src;
				OP_MULT: mach_slots[0] = mach_slots[0] * src;
				OP_DIV: begin
					if (src == '0) begin
						mach_halted = 1'b1;
						res.status = ST_DIVZERO;
					end else begin
						num = $signed(mach_slots[0]);
						den = $signed(src);
						quo = num / den;
						mach_slots[0] = quo[DATA_WIDTH-1:0];
					end
				end
				default: begin
					mach_slots[idx] = mach_slots[0];
					mach_slots[0] = '0;
				end
			endcase
		end
		res.acc = 32'(mach_slots[0]);
		res.slot_val = (res.status == ST_OK && act != OP_LOADI) ? 32'(mach_slots[idx]) : res.acc;
		return res;
	endfunction

	task automatic send_instr(input logic [3:0] act, input logic [31:0] opnd);
		int unsigned gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 20);
			if (gaps_on) begin
				gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 45) : $urandom_range(0, 3);
				if (gap != 0) begin
					s_tvalid <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
		burst_left--;
		s_tvalid <= 1'b1;
		s_tdata <= {{(IN_W-36){1'b0}}, opnd, act};
		@(posedge clk);
		while (s_tready !== 1'b1) @(posedge clk);
		pending_results.push_back(execute_instr(act, opnd));
	endtask

	task automatic test_directed_ops();
		gaps_on = 1'b1;
		send_instr(OP_LOADI, 32'h7FFF_FFFF);
		send_instr(OP_STORE, 1);
		send_instr(OP_LOADI, 32'h8000_0000);
		send_instr(OP_STORE, 2);
		send_instr(OP_LOADI, 32'hFFFF_FFFF);
		send_instr(OP_STORE, 3);
		send_instr(OP_LOAD, 1);
		send_instr(OP_ADD, 1);
		send_instr(OP_SUB, 2);
		send_instr(OP_MULT, 1);
		send_instr(OP_LOAD, 2);
		send_instr(OP_DIV, 3);
		send_instr(OP_LOADI, -32'sd7);
		send_instr(OP_STORE, 4);
		send_instr(OP_LOADI, 2);
		send_instr(OP_STORE, 5);
		send_instr(OP_LOAD, 4);
		send_instr(OP_DIV, 5);
		send_instr(OP_LOADI, 20);
		send_instr(OP_DIV, 4);
		send_instr(OP_MULT, 3);
		send_instr(OP_STORE, 0);
		send_instr(OP_ADD, NUM_SLOTS - 1);
		send_instr(OP_LOADI, 0);
	endtask

	task automatic test_random_programs(input int unsigned n_items);
		logic [3:0]  act;
		logic [31:0] opnd;
		int unsigned pick;
		for (int unsigned i = 0; i < n_items; i++) begin
			if (i % 100 == 0) gaps_on = ($urandom_range(0, 2) != 0);
			pick = $urandom_range(0, 99);
			opnd = $urandom_range(0, NUM_SLOTS - 1);
			if (pick < 22) act = OP_LOADI;
			else if (pick < 34) act = OP_LOAD;
			else if (pick < 46) act = OP_ADD;
			else if (pick < 58) act = OP_SUB;
			else if (pick < 70) act = OP_MULT;
			else if (pick < 84) act = OP_DIV;
			else act = OP_STORE;
			if (act == OP_LOADI) begin
				case ($urandom_range(0, 4))
					0: opnd = $urandom();
					1: opnd = $urandom_range(0, 20);
					2: opnd = 32'(-int'($urandom_range(1, 20)));
					3: begin
						case ($urandom_range(0, 3))
							0: opnd = 32'h7FFF_FFFF;
							1: opnd = 32'h8000_0000;
							2: opnd = 32'hFFFF_FFFF;
							default: opnd = 32'h0000_0001;
						endcase
					end
					default: opnd = $urandom() >> $urandom_range(0, 31);
				endcase
			end else if (act == OP_DIV && mach_slots[opnd] == '0) begin
				act = OP_SUB;
			end
			send_instr(act, opnd);
		end
	endtask

	task automatic test_output_backpressure();
		gaps_on = 1'b0;
		hold_off_req = 1'b1;
		send_instr(OP_LOADI, $urandom());
		send_instr(OP_STORE, 6);
		send_instr(OP_LOADI, $urandom_range(1, 1000));
		send_instr(OP_MULT, 6);
		send_instr(OP_ADD, 6);
		send_instr(OP_LOAD, 6);
		send_instr(OP_SUB, 0);
		send_instr(OP_LOADI, 32'h8000_0000);
	endtask

	task automatic test_halt_and_after();
		logic [3:0]  act;
		logic [31:0] opnd;
		int unsigned slot_k;
		gaps_on = 1'b1;
		case ($urandom_range(0, 3))
			0: send_instr(OP_END, $urandom());
			1: begin
				act = $urandom_range(0, 1) ? OP_SET : 4'($urandom_range(OP_END + 1, 4'hF));
				send_instr(act, $urandom());
			end
			2: begin
				act = 4'(OP_LOAD + $urandom_range(0, OP_STORE - OP_LOAD));
				case ($urandom_range(0, 3))
					0: opnd = NUM_SLOTS;
					1: opnd = 32'hFFFF_FFFF;
					2: opnd = $urandom() | 32'h8000_0000;
					default: opnd = $urandom_range(NUM_SLOTS, 32'h7FFF_FFFF);
				endcase
				send_instr(act, opnd);
			end
			default: begin
				slot_k = $urandom_range(1, NUM_SLOTS - 1);
				send_instr(OP_LOADI, 0);
				send_instr(OP_STORE, slot_k);
				send_instr(OP_LOADI, $urandom() | 32'h1);
				send_instr(OP_DIV, slot_k);
			end
		endcase
		for (int i = 0; i < 40; i++) send_instr(4'($urandom()), $urandom());
	endtask

	initial begin : output_stall
		int unsigned hold_left;
		int unsigned phase;
		logic [15:0] pat;
		hold_left = 0;
		phase = 0;
		pat = '1;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left != 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				if (phase == 0) begin
					pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom() | $urandom());
				end
				m_tready <= pat[phase];
				phase = (phase + 1) % 16;
			end
		end
	end

	initial begin : result_check
		outcome_t    want;
		logic [2:0]  got_status;
		logic [31:0] got_acc;
		logic [31:0] got_slot;
		forever begin
			@(posedge clk);
			if (m_tvalid === 1'b1 && m_tready === 1'b1) begin
				got_status = m_tdata[2:0];
				got_acc = m_tdata[34:3];
				got_slot = m_tdata[66:35];
				if (pending_results.size() == 0) begin
					$error("result item with nothing pending: status %0d", got_status);
					err_count++;
				end else begin
					want = pending_results.pop_front();
					if (got_status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got_status);
						err_count++;
					end
					if (got_acc !== want.acc) begin
						$error("accumulator: expected %0h, got %0h", want.acc, got_acc);
						err_count++;
					end
					if (got_slot !== want.slot_val) begin
						$error("slot_value: expected %0h, got %0h", want.slot_val, got_slot);
						err_count++;
					end
				end
			end
		end
	end

	initial begin : watchdog
		int unsigned quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
			else quiet_cycles++;
		end
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : main_seq
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed_ops();
		test_random_programs(900);
		test_output_backpressure();
		test_halt_and_after();
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0) $display("Simulation PASSED");
		else $display("Simulation FAILED");
		$finish;
	end

endmodule
